[hdl/hrt_pkg.sv]
// Package with the shared types, character codes and helpers of the HTTP request tokenizer.
package hrt_pkg;

    // Largest number of headers that get a distinct index.
    localparam int MAX_HEADERS = 16;

    // Highest header index; it also fits the 4-bit index field.
    localparam logic [3:0] HDR_CAP = (MAX_HEADERS > 16) ? 4'd15 : 4'(MAX_HEADERS - 1);

    // Result queue depth; one accepted byte can push two entries.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Character codes used by the parser.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_METHOD     = 4'd0,
        PH_URL_START  = 4'd1,
        PH_URL        = 4'd2,
        PH_VER_START  = 4'd3,
        PH_VER        = 4'd4,
        PH_SKIP_ONE   = 4'd5,
        PH_LINE_START = 4'd6,
        PH_CR_HELD    = 4'd7,
        PH_NAME       = 4'd8,
        PH_SKIP_SP    = 4'd9,
        PH_VALUE      = 4'd10,
        PH_BODY_START = 4'd11,
        PH_BODY       = 4'd12
    } t_phase;

    // Field class of a byte.
    typedef enum logic [2:0] {
        CL_METHOD  = 3'd0,
        CL_URL     = 3'd1,
        CL_VERSION = 3'd2,
        CL_NAME    = 3'd3,
        CL_VALUE   = 3'd4,
        CL_BODY    = 3'd5,
        CL_DELIM   = 3'd6
    } t_class;

    // Method decision.
    typedef enum logic [1:0] {
        MTH_PENDING = 2'd0,
        MTH_GET     = 2'd1,
        MTH_POST    = 2'd2,
        MTH_OTHER   = 2'd3
    } t_method;

    // One result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        t_class     byte_class;
        logic       field_start;
        logic [3:0] header_index;
        t_method    method_code;
        logic       msg_done;
        logic       incomplete;
        logic       run_last;
    } t_result;

    // Results produced by one accepted byte, first result in res0.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_core_out;

    // Letters of "GET".
    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h47;
            2'd1:    c = 8'h45;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

    // Letters of "POST".
    function automatic logic [7:0] post_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h50;
            2'd1:    c = 8'h4F;
            2'd2:    c = 8'h53;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

endpackage

[hdl/hrt_if.sv]
// Handshake channels of the HTTP request tokenizer: request bytes in, tagged bytes out.
interface hrt_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       msg_last;

    modport source (output valid, output data_byte, output msg_last, input ready);
    modport sink   (input valid, input data_byte, input msg_last, output ready);
endinterface

interface hrt_tok_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] byte_class;
    logic       field_start;
    logic [3:0] header_index;
    logic [1:0] method_code;
    logic       msg_done;
    logic       incomplete;
    logic       run_last;

    modport source (output valid, output out_byte, output byte_class, output field_start,
                    output header_index, output method_code, output msg_done,
                    output incomplete, output run_last, input ready);
    modport sink   (input valid, input out_byte, input byte_class, input field_start,
                    input header_index, input method_code, input msg_done,
                    input incomplete, input run_last, output ready);
endinterface

[hdl/hrt_core.sv]
// Parser state machine: classifies each accepted byte into zero, one or two results.
module hrt_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_data_byte,
    input  logic              i_msg_last,
    output hrt_pkg::t_core_out o_out
);

    hrt_pkg::t_phase  r_phase, n_phase;
    logic [2:0]       r_pos, n_pos;
    logic             r_get_match, n_get_match;
    logic             r_post_match, n_post_match;
    hrt_pkg::t_method r_method, n_method;
    logic [3:0]       r_hdr_cnt, n_hdr_cnt;
    logic             r_hdr_seen, n_hdr_seen;

    logic             hdr_bump;
    logic             m_get, m_post;
    hrt_pkg::t_method m_method;
    logic             is_cr, is_lf, is_sp, is_colon, is_eol, in_body;

    logic [1:0]       res_cnt;
    logic [7:0]       b0, b1;
    hrt_pkg::t_class  c0, c1;
    logic             s0, s1;

    assign is_cr    = (i_data_byte == hrt_pkg::CH_CR);
    assign is_lf    = (i_data_byte == hrt_pkg::CH_LF);
    assign is_sp    = (i_data_byte == hrt_pkg::CH_SP);
    assign is_colon = (i_data_byte == hrt_pkg::CH_COLON);
    assign is_eol   = is_cr || is_lf;

    // Method prefix match on the first bytes of the message.
    always_comb begin
        m_get    = r_get_match;
        m_post   = r_post_match;
        m_method = r_method;
        if (r_method == hrt_pkg::MTH_PENDING) begin
            if (r_pos < 3'd3 && r_get_match) begin
                m_get = (i_data_byte == hrt_pkg::get_char(r_pos[1:0]));
            end
            if (r_pos < 3'd4 && r_post_match) begin
                m_post = (i_data_byte == hrt_pkg::post_char(r_pos[1:0]));
            end
            if (m_get) begin
                if (r_pos == 3'd2) begin
                    m_method = hrt_pkg::MTH_GET;
                end
            end else if (m_post) begin
                if (r_pos == 3'd3) begin
                    m_method = hrt_pkg::MTH_POST;
                end
            end else begin
                m_method = hrt_pkg::MTH_OTHER;
            end
        end
    end

    // Next phase and method tracking.
    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_get_match  = r_get_match;
        n_post_match = r_post_match;
        n_method     = r_method;
        hdr_bump     = 1'b0;
        unique case (r_phase)
            hrt_pkg::PH_METHOD: begin
                n_get_match  = m_get;
                n_post_match = m_post;
                n_method     = m_method;
                if (is_sp) begin
                    n_phase = hrt_pkg::PH_URL_START;
                end
                if (r_pos < 3'd7) begin
                    n_pos = r_pos + 3'd1;
                end
            end
            hrt_pkg::PH_URL_START, hrt_pkg::PH_URL: begin
                n_phase = is_sp ? hrt_pkg::PH_VER_START : hrt_pkg::PH_URL;
            end
            hrt_pkg::PH_VER_START, hrt_pkg::PH_VER: begin
                n_phase = is_eol ? hrt_pkg::PH_SKIP_ONE : hrt_pkg::PH_VER;
            end
            hrt_pkg::PH_SKIP_ONE: begin
                n_phase = hrt_pkg::PH_LINE_START;
            end
            hrt_pkg::PH_LINE_START: begin
                if (is_cr) begin
                    n_phase = hrt_pkg::PH_CR_HELD;
                end else begin
                    hdr_bump = 1'b1;
                    n_phase  = is_colon ? hrt_pkg::PH_SKIP_SP : hrt_pkg::PH_NAME;
                end
            end
            hrt_pkg::PH_CR_HELD: begin
                if (is_lf) begin
                    n_phase = hrt_pkg::PH_BODY_START;
                end else begin
                    hdr_bump = 1'b1;
                    n_phase  = is_colon ? hrt_pkg::PH_SKIP_SP : hrt_pkg::PH_NAME;
                end
            end
            hrt_pkg::PH_NAME: begin
                if (is_colon) begin
                    n_phase = hrt_pkg::PH_SKIP_SP;
                end
            end
            hrt_pkg::PH_SKIP_SP, hrt_pkg::PH_VALUE: begin
                if (is_eol) begin
                    n_phase = hrt_pkg::PH_SKIP_ONE;
                end else if (!(r_phase == hrt_pkg::PH_SKIP_SP && is_sp)) begin
                    n_phase = hrt_pkg::PH_VALUE;
                end
            end
            default: begin
                n_phase = hrt_pkg::PH_BODY;
            end
        endcase
        // A CR held at the end of the message is flushed as a name byte.
        if (i_msg_last && n_phase == hrt_pkg::PH_CR_HELD) begin
            hdr_bump = 1'b1;
            n_phase  = hrt_pkg::PH_NAME;
        end
    end

    // Header index: the first header gets zero, later ones count up and saturate.
    always_comb begin
        n_hdr_cnt  = r_hdr_cnt;
        n_hdr_seen = r_hdr_seen;
        if (hdr_bump) begin
            if (!r_hdr_seen) begin
                n_hdr_seen = 1'b1;
                n_hdr_cnt  = 4'd0;
            end else if (r_hdr_cnt < hrt_pkg::HDR_CAP) begin
                n_hdr_cnt = r_hdr_cnt + 4'd1;
            end
        end
    end

    assign in_body = (n_phase == hrt_pkg::PH_BODY_START) || (n_phase == hrt_pkg::PH_BODY);

    // Byte, class and field start of each result.
    always_comb begin
        res_cnt = 2'd1;
        b0      = i_data_byte;
        c0      = hrt_pkg::CL_DELIM;
        s0      = 1'b0;
        b1      = i_data_byte;
        c1      = hrt_pkg::CL_DELIM;
        s1      = 1'b0;
        unique case (r_phase)
            hrt_pkg::PH_METHOD: begin
                if (!is_sp) begin
                    c0 = hrt_pkg::CL_METHOD;
                    s0 = (r_pos == 3'd0);
                end
            end
            hrt_pkg::PH_URL_START, hrt_pkg::PH_URL: begin
                if (!is_sp) begin
                    c0 = hrt_pkg::CL_URL;
                    s0 = (r_phase == hrt_pkg::PH_URL_START);
                end
            end
            hrt_pkg::PH_VER_START, hrt_pkg::PH_VER: begin
                if (!is_eol) begin
                    c0 = hrt_pkg::CL_VERSION;
                    s0 = (r_phase == hrt_pkg::PH_VER_START);
                end
            end
            hrt_pkg::PH_SKIP_ONE: begin
                c0 = hrt_pkg::CL_DELIM;
            end
            hrt_pkg::PH_LINE_START: begin
                if (is_cr) begin
                    // The CR is held; only a message end releases it now.
                    res_cnt = i_msg_last ? 2'd1 : 2'd0;
                    b0      = hrt_pkg::CH_CR;
                    c0      = hrt_pkg::CL_NAME;
                    s0      = 1'b1;
                end else if (!is_colon) begin
                    c0 = hrt_pkg::CL_NAME;
                    s0 = 1'b1;
                end
            end
            hrt_pkg::PH_CR_HELD: begin
                res_cnt = 2'd2;
                b0      = hrt_pkg::CH_CR;
                if (is_lf) begin
                    c0 = hrt_pkg::CL_DELIM;
                end else begin
                    c0 = hrt_pkg::CL_NAME;
                    s0 = 1'b1;
                    c1 = is_colon ? hrt_pkg::CL_DELIM : hrt_pkg::CL_NAME;
                end
            end
            hrt_pkg::PH_NAME: begin
                if (!is_colon) begin
                    c0 = hrt_pkg::CL_NAME;
                end
            end
            hrt_pkg::PH_SKIP_SP, hrt_pkg::PH_VALUE: begin
                if (!is_eol && !(r_phase == hrt_pkg::PH_SKIP_SP && is_sp)) begin
                    c0 = hrt_pkg::CL_VALUE;
                    s0 = (r_phase == hrt_pkg::PH_SKIP_SP);
                end
            end
            default: begin
                c0 = hrt_pkg::CL_BODY;
                s0 = (r_phase == hrt_pkg::PH_BODY_START);
            end
        endcase
    end

    // Assemble the result beats; shared fields carry the state after this byte.
    always_comb begin
        o_out.count                  = i_fire ? res_cnt : 2'd0;
        o_out.res0.out_byte          = b0;
        o_out.res0.byte_class        = c0;
        o_out.res0.field_start       = s0;
        o_out.res0.header_index      = n_hdr_cnt;
        o_out.res0.method_code       = n_method;
        o_out.res0.run_last          = (res_cnt != 2'd2);
        o_out.res0.msg_done          = i_msg_last && (res_cnt != 2'd2);
        o_out.res0.incomplete        = i_msg_last && (res_cnt != 2'd2) && !in_body;
        o_out.res1.out_byte          = b1;
        o_out.res1.byte_class        = c1;
        o_out.res1.field_start       = s1;
        o_out.res1.header_index      = n_hdr_cnt;
        o_out.res1.method_code       = n_method;
        o_out.res1.run_last          = 1'b1;
        o_out.res1.msg_done          = i_msg_last;
        o_out.res1.incomplete        = i_msg_last && !in_body;
    end

    // State registers; the final byte of a message returns everything to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_msg_last)) begin
            r_phase      <= hrt_pkg::PH_METHOD;
            r_pos        <= 3'd0;
            r_get_match  <= 1'b1;
            r_post_match <= 1'b1;
            r_method     <= hrt_pkg::MTH_PENDING;
            r_hdr_cnt    <= 4'd0;
            r_hdr_seen   <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_get_match  <= n_get_match;
            r_post_match <= n_post_match;
            r_method     <= n_method;
            r_hdr_cnt    <= n_hdr_cnt;
            r_hdr_seen   <= n_hdr_seen;
        end
    end

endmodule

[hdl/hrt_out_queue.sv]
// Small result queue that takes up to two beats per cycle and hands out one while the receiver is ready.
module hrt_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hrt_pkg::t_core_out i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output hrt_pkg::t_result   o_result
);

    hrt_pkg::t_result                r_mem [hrt_pkg::QUEUE_DEPTH];
    logic [hrt_pkg::QUEUE_AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [hrt_pkg::QUEUE_AW:0]      r_count;
    logic                            pop;
    logic [hrt_pkg::QUEUE_AW-1:0]    wr_ptr_1;

    // Room for a full two-beat push is judged from the registered fill level.
    assign o_room   = (r_count <= (hrt_pkg::QUEUE_AW + 1)'(hrt_pkg::QUEUE_DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_ready;
    assign wr_ptr_1 = r_wr_ptr + 1'b1;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.res1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + hrt_pkg::QUEUE_AW'(i_push.count);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (hrt_pkg::QUEUE_AW + 1)'(i_push.count)
                       - (hrt_pkg::QUEUE_AW + 1)'(pop);
        end
    end

endmodule

[hdl/http_request_tokenizer.sv]
// Top level of the HTTP request tokenizer: byte channel in, tagged byte channel out.
//
// The request channel takes one raw byte per beat, with msg_last on the final byte of a
// message. The token channel gives one beat per classified byte: the byte, its field
// class, a field start flag, the header index, the method code and the end flags.
// Most bytes give one beat; a CR at the start of a header line gives none until the next
// byte arrives, and that next byte then gives two beats (or the CR alone at message end).
// A beat is written into the result queue before it is visible on the token channel.
// Throughput: one byte per cycle while the receiver takes one beat per cycle; the two beats
// of one byte leave one after the other. The parser state machine settles each byte
// combinationally; the four-entry result queue sets how far the sides decouple.
// The request channel is ready while the queue has room for two beats, so it keeps
// accepting while a finished beat waits; when the receiver stalls, the queue fills and
// ready drops once three or four beats are pending, and no beat is lost.
// Reset clears the parser to the method phase and empties the queue. The final byte of
// each message also returns the parser to its reset state.
module http_request_tokenizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrt_req_if.sink   i_req,
    hrt_tok_if.source o_tok
);

    hrt_pkg::t_core_out core_out;
    hrt_pkg::t_result   result;
    logic               room;
    logic               fire;

    assign i_req.ready = room;
    assign fire        = i_req.valid && room;

    // Byte classifier.
    hrt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (i_req.data_byte),
        .i_msg_last  (i_req.msg_last),
        .o_out       (core_out)
    );

    // Result queue toward the token channel.
    hrt_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (core_out),
        .o_room   (room),
        .o_valid  (o_tok.valid),
        .i_ready  (o_tok.ready),
        .o_result (result)
    );

    // Token channel payload.
    assign o_tok.out_byte     = result.out_byte;
    assign o_tok.byte_class   = result.byte_class;
    assign o_tok.field_start  = result.field_start;
    assign o_tok.header_index = result.header_index;
    assign o_tok.method_code  = result.method_code;
    assign o_tok.msg_done     = result.msg_done;
    assign o_tok.incomplete   = result.incomplete;
    assign o_tok.run_last     = result.run_last;

endmodule

[tb/testbench.sv]
// Self-checking testbench of the HTTP request tokenizer: directed and random requests.
module testbench;

    // Letters of the two recognized methods, first letter in the top byte.
    localparam logic [23:0] GET_WORD  = 24'h474554;
    localparam logic [31:0] POST_WORD = 32'h504F5354;

    localparam int MAX_GAP      = 10;
    localparam int RANDOM_BYTES = 210;
    localparam int HOLD_CYCLES  = 60;
    localparam int TAIL_CYCLES  = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hrt_req_if req_ch ();
    hrt_tok_if tok_ch ();

    http_request_tokenizer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_tok   (tok_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected token beats, oldest first, and the bytes of the message being built.
    hrt_pkg::t_result tok_expect [$];
    logic [7:0]       msg_bytes [$];
    int               mismatches = 0;

    // Pacing of both channels.
    bit req_burst = 1'b0;
    bit tok_burst = 1'b0;
    int tok_wait  = 0;
    int tok_hold  = 0;

    // Mirror of the parser state.
    hrt_pkg::t_phase  prs_phase;
    logic [2:0]       prs_pos;
    logic             prs_get_ok;
    logic             prs_post_ok;
    hrt_pkg::t_method prs_method;
    logic [3:0]       prs_hdr;
    logic             prs_hdr_seen;

    // Beats produced by the byte being classified.
    hrt_pkg::t_result tok_pend [2];
    int               tok_pend_n;

    function automatic void parser_reset();
        prs_phase    = hrt_pkg::PH_METHOD;
        prs_pos      = 3'd0;
        prs_get_ok   = 1'b1;
        prs_post_ok  = 1'b1;
        prs_method   = hrt_pkg::MTH_PENDING;
        prs_hdr      = 4'd0;
        prs_hdr_seen = 1'b0;
    endfunction

    function automatic void add_token(input logic [7:0] b, input hrt_pkg::t_class cls,
                                      input logic start);
        hrt_pkg::t_result r;
        r              = '0;
        r.out_byte     = b;
        r.byte_class   = cls;
        r.field_start  = start;
        tok_pend[tok_pend_n] = r;
        tok_pend_n++;
    endfunction

    // The first header gets index zero; later ones count up to the cap.
    function automatic void open_header();
        if (!prs_hdr_seen) begin
            prs_hdr_seen = 1'b1;
            prs_hdr      = 4'd0;
        end else if (prs_hdr < hrt_pkg::HDR_CAP) begin
            prs_hdr++;
        end
    endfunction

    // Prefix match of the opening bytes against GET, then POST.
    function automatic void track_method(input logic [7:0] b);
        int p;
        p = int'(prs_pos);
        if (prs_method != hrt_pkg::MTH_PENDING) return;
        if (p < 3 && prs_get_ok) prs_get_ok = (b == GET_WORD[23 - 8 * p -: 8]);
        if (p < 4 && prs_post_ok) prs_post_ok = (b == POST_WORD[31 - 8 * p -: 8]);
        if (prs_get_ok) begin
            if (p == 2) prs_method = hrt_pkg::MTH_GET;
        end else if (prs_post_ok) begin
            if (p == 3) prs_method = hrt_pkg::MTH_POST;
        end else begin
            prs_method = hrt_pkg::MTH_OTHER;
        end
    endfunction

    function automatic void step_phase(input logic [7:0] b);
        logic eol;
        eol = (b == hrt_pkg::CH_CR) || (b == hrt_pkg::CH_LF);
        case (prs_phase)
            hrt_pkg::PH_METHOD: begin
                track_method(b);
                if (b == hrt_pkg::CH_SP) begin
                    add_token(b, hrt_pkg::CL_DELIM, 1'b0);
                    prs_phase = hrt_pkg::PH_URL_START;
                end else begin
                    add_token(b, hrt_pkg::CL_METHOD, prs_pos == 3'd0);
                end
                if (prs_pos < 3'd7) prs_pos++;
            end
            hrt_pkg::PH_URL_START, hrt_pkg::PH_URL: begin
                if (b == hrt_pkg::CH_SP) begin
                    add_token(b, hrt_pkg::CL_DELIM, 1'b0);
                    prs_phase = hrt_pkg::PH_VER_START;
                end else begin
                    add_token(b, hrt_pkg::CL_URL, prs_phase == hrt_pkg::PH_URL_START);
                    prs_phase = hrt_pkg::PH_URL;
                end
            end
            hrt_pkg::PH_VER_START, hrt_pkg::PH_VER: begin
                if (eol) begin
                    add_token(b, hrt_pkg::CL_DELIM, 1'b0);
                    prs_phase = hrt_pkg::PH_SKIP_ONE;
                end else begin
                    add_token(b, hrt_pkg::CL_VERSION, prs_phase == hrt_pkg::PH_VER_START);
                    prs_phase = hrt_pkg::PH_VER;
                end
            end
            hrt_pkg::PH_SKIP_ONE: begin
                add_token(b, hrt_pkg::CL_DELIM, 1'b0);
                prs_phase = hrt_pkg::PH_LINE_START;
            end
            hrt_pkg::PH_LINE_START: begin
                if (b == hrt_pkg::CH_CR) begin
                    prs_phase = hrt_pkg::PH_CR_HELD;
                end else begin
                    open_header();
                    if (b == hrt_pkg::CH_COLON) begin
                        add_token(b, hrt_pkg::CL_DELIM, 1'b0);
                        prs_phase = hrt_pkg::PH_SKIP_SP;
                    end else begin
                        add_token(b, hrt_pkg::CL_NAME, 1'b1);
                        prs_phase = hrt_pkg::PH_NAME;
                    end
                end
            end
            hrt_pkg::PH_CR_HELD: begin
                // CR LF ends the headers; any other byte turns the CR into a name byte.
                if (b == hrt_pkg::CH_LF) begin
                    add_token(hrt_pkg::CH_CR, hrt_pkg::CL_DELIM, 1'b0);
                    add_token(b, hrt_pkg::CL_DELIM, 1'b0);
                    prs_phase = hrt_pkg::PH_BODY_START;
                end else begin
                    open_header();
                    add_token(hrt_pkg::CH_CR, hrt_pkg::CL_NAME, 1'b1);
                    prs_phase = hrt_pkg::PH_NAME;
                    step_phase(b);
                end
            end
            hrt_pkg::PH_NAME: begin
                if (b == hrt_pkg::CH_COLON) begin
                    add_token(b, hrt_pkg::CL_DELIM, 1'b0);
                    prs_phase = hrt_pkg::PH_SKIP_SP;
                end else begin
                    add_token(b, hrt_pkg::CL_NAME, 1'b0);
                end
            end
            hrt_pkg::PH_SKIP_SP, hrt_pkg::PH_VALUE: begin
                if (eol) begin
                    add_token(b, hrt_pkg::CL_DELIM, 1'b0);
                    prs_phase = hrt_pkg::PH_SKIP_ONE;
                end else if (prs_phase == hrt_pkg::PH_SKIP_SP && b == hrt_pkg::CH_SP) begin
                    add_token(b, hrt_pkg::CL_DELIM, 1'b0);
                end else begin
                    add_token(b, hrt_pkg::CL_VALUE, prs_phase == hrt_pkg::PH_SKIP_SP);
                    prs_phase = hrt_pkg::PH_VALUE;
                end
            end
            default: begin
                add_token(b, hrt_pkg::CL_BODY, prs_phase == hrt_pkg::PH_BODY_START);
                prs_phase = hrt_pkg::PH_BODY;
            end
        endcase
    endfunction

    // Works out the beats of one accepted byte and queues them.
    function automatic void classify_byte(input logic [7:0] b, input logic last);
        hrt_pkg::t_result r;
        logic             in_body;
        logic             fin;
        tok_pend_n = 0;
        step_phase(b);
        // A CR still held when the message ends is flushed as a name byte.
        if (last && prs_phase == hrt_pkg::PH_CR_HELD) begin
            open_header();
            add_token(hrt_pkg::CH_CR, hrt_pkg::CL_NAME, 1'b1);
            prs_phase = hrt_pkg::PH_NAME;
        end
        in_body = (prs_phase == hrt_pkg::PH_BODY_START) || (prs_phase == hrt_pkg::PH_BODY);
        for (int k = 0; k < tok_pend_n; k++) begin
            fin            = (k == tok_pend_n - 1);
            r              = tok_pend[k];
            r.header_index = prs_hdr;
            r.method_code  = prs_method;
            r.msg_done     = last && fin;
            r.incomplete   = last && fin && !in_body;
            r.run_last     = fin;
            tok_expect.push_back(r);
        end
        if (last) parser_reset();
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each token beat with the oldest expectation and draw the next receiver wait.
    always @(posedge i_clk) begin : tok_check
        hrt_pkg::t_result want;
        if (i_rst_n && tok_ch.valid && tok_ch.ready) begin
            tok_wait <= tok_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (tok_expect.size() == 0) begin
                $error("out_byte: expected no beat, got %0d", tok_ch.out_byte);
                mismatches++;
            end else begin
                want = tok_expect.pop_front();
                check_field("out_byte", want.out_byte, tok_ch.out_byte);
                check_field("byte_class", want.byte_class, tok_ch.byte_class);
                check_field("field_start", want.field_start, tok_ch.field_start);
                check_field("header_index", want.header_index, tok_ch.header_index);
                check_field("method_code", want.method_code, tok_ch.method_code);
                check_field("msg_done", want.msg_done, tok_ch.msg_done);
                check_field("incomplete", want.incomplete, tok_ch.incomplete);
                check_field("run_last", want.run_last, tok_ch.run_last);
            end
        end
    end

    // Receiver: a long hold-off when asked, otherwise the drawn wait after each beat.
    initial begin : tok_sink
        tok_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (tok_hold > 0) begin
                tok_hold     <= tok_hold - 1;
                tok_ch.ready <= 1'b0;
            end else if (tok_wait > 0) begin
                tok_wait     <= tok_wait - 1;
                tok_ch.ready <= 1'b0;
            end else begin
                tok_ch.ready <= 1'b1;
            end
        end
    end

    // Offers one byte after a drawn gap and returns at the edge that accepts it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.data_byte <= b;
        req_ch.msg_last  <= last;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        classify_byte(b, last);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (tok_expect.size() != 0) @(negedge i_clk);
    endtask

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
    endfunction

    // Byte source biased toward the characters the parser reacts to.
    function automatic logic [7:0] pick_byte();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = 8'($urandom_range(0, 255));
            1: begin
                case ($urandom_range(0, 7))
                    0: c = hrt_pkg::CH_CR;
                    1: c = hrt_pkg::CH_LF;
                    2: c = hrt_pkg::CH_SP;
                    3: c = hrt_pkg::CH_COLON;
                    4: c = GET_WORD[23:16];
                    5: c = GET_WORD[15:8];
                    6: c = POST_WORD[31:24];
                    default: c = POST_WORD[7:0];
                endcase
            end
            default: c = 8'($urandom_range(8'h21, 8'h7E));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_except(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        c = pick_byte();
        while (c == a || c == b) c = pick_byte();
        return c;
    endfunction

    function automatic void push_line_end();
        case ($urandom_range(0, 3))
            0, 1: begin
                msg_bytes.push_back(hrt_pkg::CH_CR);
                msg_bytes.push_back(hrt_pkg::CH_LF);
            end
            2: begin
                msg_bytes.push_back(hrt_pkg::CH_LF);
                msg_bytes.push_back(pick_byte());
            end
            default: begin
                msg_bytes.push_back(hrt_pkg::CH_CR);
                msg_bytes.push_back(pick_byte());
            end
        endcase
    endfunction

    // A request with random content; many_hdr forces 15 to 19 headers, which can saturate the index.
    function automatic void build_request(input bit many_hdr);
        int n_hdr;
        int len;
        bit tiny;
        msg_bytes.delete();
        case ($urandom_range(0, 4))
            0, 1: push_str("GET");
            2, 3: push_str("POST");
            default: repeat ($urandom_range(1, 9))
                msg_bytes.push_back(pick_except(hrt_pkg::CH_SP, hrt_pkg::CH_SP));
        endcase
        msg_bytes.push_back(hrt_pkg::CH_SP);
        repeat ($urandom_range(0, 4))
            msg_bytes.push_back(pick_except(hrt_pkg::CH_SP, hrt_pkg::CH_SP));
        msg_bytes.push_back(hrt_pkg::CH_SP);
        repeat ($urandom_range(0, 4))
            msg_bytes.push_back(pick_except(hrt_pkg::CH_CR, hrt_pkg::CH_LF));
        push_line_end();
        if (many_hdr || $urandom_range(0, 7) == 0) n_hdr = $urandom_range(15, 19);
        else n_hdr = $urandom_range(0, 3);
        tiny = (n_hdr > 4);
        for (int h = 0; h < n_hdr; h++) begin
            // Now and then a name opens with a bare CR.
            if ($urandom_range(0, 7) == 0) msg_bytes.push_back(hrt_pkg::CH_CR);
            repeat (tiny ? $urandom_range(0, 1) : $urandom_range(0, 3))
                msg_bytes.push_back(pick_except(hrt_pkg::CH_COLON, hrt_pkg::CH_CR));
            msg_bytes.push_back(hrt_pkg::CH_COLON);
            repeat ($urandom_range(0, 2)) msg_bytes.push_back(hrt_pkg::CH_SP);
            repeat (tiny ? $urandom_range(0, 1) : $urandom_range(0, 4))
                msg_bytes.push_back(pick_except(hrt_pkg::CH_CR, hrt_pkg::CH_LF));
            push_line_end();
        end
        if ($urandom_range(0, 9) == 0) begin
            msg_bytes.push_back(hrt_pkg::CH_CR);
        end else begin
            msg_bytes.push_back(hrt_pkg::CH_CR);
            msg_bytes.push_back(hrt_pkg::CH_LF);
            repeat ($urandom_range(0, 5)) msg_bytes.push_back(pick_byte());
        end
        // Some messages are cut short.
        if (!many_hdr && $urandom_range(0, 5) == 0) begin
            len = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > len) msg_bytes.delete(msg_bytes.size() - 1);
        end
    endfunction

    function automatic void build_noise();
        msg_bytes.delete();
        repeat ($urandom_range(1, 10)) msg_bytes.push_back(pick_byte());
    endfunction

    // One-byte messages: a method still pending and an unsupported one, top byte value.
    task automatic test_short_messages();
        msg_bytes.delete();
        push_str("G");
        send_message();
        msg_bytes.delete();
        msg_bytes.push_back(8'hFF);
        send_message();
        wait_drained();
    endtask

    // GET with a zero URL byte, a CR that opens a name, and a CR held when the message ends.
    task automatic test_held_cr();
        msg_bytes.delete();
        push_str("GET ");
        msg_bytes.push_back(8'h00);
        push_str(" 1");
        msg_bytes.push_back(hrt_pkg::CH_LF);
        msg_bytes.push_back(hrt_pkg::CH_LF);
        msg_bytes.push_back(hrt_pkg::CH_CR);
        push_str("A:");
        msg_bytes.push_back(hrt_pkg::CH_LF);
        msg_bytes.push_back(hrt_pkg::CH_LF);
        msg_bytes.push_back(hrt_pkg::CH_CR);
        send_message();
        wait_drained();
    endtask

    // POST with empty URL and version, a header with an empty name, then a body byte.
    task automatic test_post_body();
        msg_bytes.delete();
        push_str("POST  ");
        msg_bytes.push_back(hrt_pkg::CH_CR);
        msg_bytes.push_back(hrt_pkg::CH_LF);
        msg_bytes.push_back(hrt_pkg::CH_COLON);
        msg_bytes.push_back(hrt_pkg::CH_CR);
        msg_bytes.push_back(hrt_pkg::CH_LF);
        msg_bytes.push_back(hrt_pkg::CH_CR);
        msg_bytes.push_back(hrt_pkg::CH_LF);
        msg_bytes.push_back(8'hFF);
        send_message();
        wait_drained();
    endtask

    // The receiver stalls for a long stretch while bytes keep coming back to back.
    task automatic test_backpressure();
        wait_drained();
        tok_hold  <= HOLD_CYCLES;
        req_burst = 1'b1;
        tok_burst = 1'b0;
        build_request(1'b1);
        send_message();
        wait_drained();
    endtask

    // Random requests and noise with changing pacing and occasional drain pauses.
    task automatic test_random_traffic();
        int sent;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            req_burst = ($urandom_range(0, 3) == 0);
            tok_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) build_noise();
            else build_request(1'b0);
            sent += msg_bytes.size();
            send_message();
            if ($urandom_range(0, 4) == 0) wait_drained();
        end
    endtask

    initial begin : main
        req_ch.valid     = 1'b0;
        req_ch.data_byte = 8'h00;
        req_ch.msg_last  = 1'b0;
        parser_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_short_messages();
        test_held_cr();
        test_post_body();
        test_backpressure();
        test_random_traffic();
        test_backpressure();
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("http_request_tokenizer: match");
        end else begin
            $display("http_request_tokenizer: mismatch");
        end
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin : watchdog
        #2000000;
        $display("http_request_tokenizer: mismatch");
        $finish;
    end

endmodule

[http_request_tokenizer.f]
hdl/hrt_pkg.sv
hdl/hrt_if.sv
hdl/hrt_core.sv
hdl/hrt_out_queue.sv
hdl/http_request_tokenizer.sv
tb/testbench.sv
